@@ hw/rtl/md5c_pkg.sv @@
// ----------------------------------------------------------------------------
// md5c_pkg
// Shared types, step tables and message padding helper for the MD5
// single-block candidate hash pipeline.
// ----------------------------------------------------------------------------
package md5c_pkg;

	localparam int unsigned StepCount = 64;
	localparam int unsigned StepBits  = 6;

	typedef logic [31:0] word_t;
	typedef logic [StepBits-1:0] step_t;

	typedef struct packed {
		word_t a;
		word_t b;
		word_t c;
		word_t d;
	} md5_state_t;

	// message words that are fixed for a whole run of candidates
	typedef struct packed {
		word_t      w1;
		word_t      w2;
		word_t      w3;
		logic [6:0] len_bits;
	} msg_cfg_t;

	// configuration register indexes
	localparam logic [1:0] RegLength   = 2'd0;
	localparam logic [1:0] RegSuffixW1 = 2'd1;
	localparam logic [1:0] RegSuffixW2 = 2'd2;
	localparam logic [1:0] RegSuffixW3 = 2'd3;

	// message word positions with content
	localparam logic [3:0] WordCand   = 4'd0;
	localparam logic [3:0] WordSuf1   = 4'd1;
	localparam logic [3:0] WordSuf2   = 4'd2;
	localparam logic [3:0] WordSuf3   = 4'd3;
	localparam logic [3:0] WordLength = 4'd14;

	localparam word_t InitA = 32'h67452301;
	localparam word_t InitB = 32'hefcdab89;
	localparam word_t InitC = 32'h98badcfe;
	localparam word_t InitD = 32'h10325476;

	localparam logic [7:0] PadByte = 8'h80;

	localparam word_t RoundConst [StepCount] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	localparam logic [4:0] RotAmount [StepCount] = '{
		5'd7, 5'd12, 5'd17, 5'd22, 5'd7, 5'd12, 5'd17, 5'd22,
		5'd7, 5'd12, 5'd17, 5'd22, 5'd7, 5'd12, 5'd17, 5'd22,
		5'd5, 5'd9, 5'd14, 5'd20, 5'd5, 5'd9, 5'd14, 5'd20,
		5'd5, 5'd9, 5'd14, 5'd20, 5'd5, 5'd9, 5'd14, 5'd20,
		5'd4, 5'd11, 5'd16, 5'd23, 5'd4, 5'd11, 5'd16, 5'd23,
		5'd4, 5'd11, 5'd16, 5'd23, 5'd4, 5'd11, 5'd16, 5'd23,
		5'd6, 5'd10, 5'd15, 5'd21, 5'd6, 5'd10, 5'd15, 5'd21,
		5'd6, 5'd10, 5'd15, 5'd21, 5'd6, 5'd10, 5'd15, 5'd21
	};

	localparam logic [3:0] WordPick [StepCount] = '{
		4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
		4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15,
		4'd1, 4'd6, 4'd11, 4'd0, 4'd5, 4'd10, 4'd15, 4'd4,
		4'd9, 4'd14, 4'd3, 4'd8, 4'd13, 4'd2, 4'd7, 4'd12,
		4'd5, 4'd8, 4'd11, 4'd14, 4'd1, 4'd4, 4'd7, 4'd10,
		4'd13, 4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15, 4'd2,
		4'd0, 4'd7, 4'd14, 4'd5, 4'd12, 4'd3, 4'd10, 4'd1,
		4'd8, 4'd15, 4'd6, 4'd13, 4'd4, 4'd11, 4'd2, 4'd9
	};

	// or the pad byte into word idx when byte position len falls inside it
	function automatic word_t pad_word(input word_t w, input logic [1:0] idx,
			input logic [3:0] len);
		word_t pad;
		pad = word_t'(PadByte) << {len[1:0], 3'b000};
		if (len[3:2] == idx) begin
			return w | pad;
		end
		return w;
	endfunction

endpackage

@@ hw/rtl/md5c_step.sv @@
// ----------------------------------------------------------------------------
// md5c_step
// One MD5 step: round function, four-way add, rotate and add into b.
// ----------------------------------------------------------------------------
module md5c_step (
	input  md5c_pkg::step_t      step,
	input  md5c_pkg::md5_state_t cur,
	input  md5c_pkg::word_t      word0,
	input  md5c_pkg::msg_cfg_t   cfg,
	output md5c_pkg::md5_state_t nxt
);

	md5c_pkg::word_t f;
	md5c_pkg::word_t m;
	md5c_pkg::word_t t;
	md5c_pkg::word_t rot;
	logic [4:0]      sh;
	logic [3:0]      pick;

	assign sh   = md5c_pkg::RotAmount[step];
	assign pick = md5c_pkg::WordPick[step];

	always_comb begin
		unique case (step[5:4])
			2'd0: f = cur.d ^ (cur.b & (cur.c ^ cur.d));
			2'd1: f = cur.c ^ (cur.d & (cur.b ^ cur.c));
			2'd2: f = cur.b ^ cur.c ^ cur.d;
			default: f = cur.c ^ (cur.b | ~cur.d);
		endcase
	end

	always_comb begin
		unique case (pick)
			md5c_pkg::WordCand:   m = word0;
			md5c_pkg::WordSuf1:   m = cfg.w1;
			md5c_pkg::WordSuf2:   m = cfg.w2;
			md5c_pkg::WordSuf3:   m = cfg.w3;
			md5c_pkg::WordLength: m = {25'd0, cfg.len_bits};
			default:              m = '0;
		endcase
	end

	assign t = cur.a + f + md5c_pkg::RoundConst[step] + m;

	// rotation amounts are never zero
	assign rot = (t << sh) | (t >> (6'd32 - {1'b0, sh}));

	assign nxt.a = cur.d;
	assign nxt.b = cur.b + rot;
	assign nxt.c = cur.b;
	assign nxt.d = cur.c;

endmodule

@@ hw/rtl/md5_single_block_candidate_hash.sv @@
// pipeline: one md5 step per stage register, the last stage register holding the result
// throughput: one request per cycle while out_ready is high
// the whole step pipeline stalls only when a finished result is not taken
// reset: arst_n clears all stage valid bits and the configuration registers
// ----------------------------------------------------------------------------
// md5_single_block_candidate_hash
// 64-stage pipelined md5 compression of one padded block per candidate
// prefix word, returning the raw state without feed-forward.
// ----------------------------------------------------------------------------
module md5_single_block_candidate_hash (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write_en,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] first_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] state_a,
	output logic [31:0] state_b,
	output logic [31:0] state_c,
	output logic [31:0] state_d
);

	localparam int unsigned Last = md5c_pkg::StepCount - 1;

	logic [3:0]         msg_len_q;
	md5c_pkg::word_t    suffix_w1_q;
	md5c_pkg::word_t    suffix_w2_q;
	md5c_pkg::word_t    suffix_w3_q;
	md5c_pkg::msg_cfg_t msg_cfg;

	logic                 adv;
	md5c_pkg::word_t      word0_in;
	md5c_pkg::md5_state_t init_state;

	logic [Last:0]        valid_s;
	md5c_pkg::md5_state_t state_s [md5c_pkg::StepCount];
	md5c_pkg::word_t      word_s  [Last];
	md5c_pkg::md5_state_t nxt     [md5c_pkg::StepCount];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_len_q   <= '0;
			suffix_w1_q <= '0;
			suffix_w2_q <= '0;
			suffix_w3_q <= '0;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				md5c_pkg::RegLength:   msg_len_q   <= cfg_data[3:0];
				md5c_pkg::RegSuffixW1: suffix_w1_q <= cfg_data;
				md5c_pkg::RegSuffixW2: suffix_w2_q <= cfg_data;
				md5c_pkg::RegSuffixW3: suffix_w3_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// the user must keep the configuration static while requests are in flight; the block does not enforce it
	assign msg_cfg.w1       = md5c_pkg::pad_word(suffix_w1_q, 2'd1, msg_len_q);
	assign msg_cfg.w2       = md5c_pkg::pad_word(suffix_w2_q, 2'd2, msg_len_q);
	assign msg_cfg.w3       = md5c_pkg::pad_word(suffix_w3_q, 2'd3, msg_len_q);
	assign msg_cfg.len_bits = {msg_len_q, 3'b000};

	assign word0_in = md5c_pkg::pad_word(first_word, 2'd0, msg_len_q);

	assign init_state.a = md5c_pkg::InitA;
	assign init_state.b = md5c_pkg::InitB;
	assign init_state.c = md5c_pkg::InitC;
	assign init_state.d = md5c_pkg::InitD;

	// last stage is the output register
	assign adv      = !valid_s[Last] || out_ready;
	assign in_ready = adv;

	generate
		for (genvar k = 0; k < md5c_pkg::StepCount; k++) begin : g_stage
			if (k == 0) begin : g_first
				md5c_step u_step (
					.step  (md5c_pkg::step_t'(k)),
					.cur   (init_state),
					.word0 (word0_in),
					.cfg   (msg_cfg),
					.nxt   (nxt[k])
				);

				always_ff @(posedge clk or negedge arst_n) begin
					if (!arst_n) begin
						valid_s[k] <= 1'b0;
					end else if (adv) begin
						valid_s[k] <= in_valid;
					end
				end
			end else begin : g_rest
				md5c_step u_step (
					.step  (md5c_pkg::step_t'(k)),
					.cur   (state_s[k-1]),
					.word0 (word_s[k-1]),
					.cfg   (msg_cfg),
					.nxt   (nxt[k])
				);

				always_ff @(posedge clk or negedge arst_n) begin
					if (!arst_n) begin
						valid_s[k] <= 1'b0;
					end else if (adv) begin
						valid_s[k] <= valid_s[k-1];
					end
				end
			end

			always_ff @(posedge clk) begin
				if (adv) begin
					state_s[k] <= nxt[k];
				end
			end

			if (k < Last) begin : g_word
				always_ff @(posedge clk) begin
					if (adv) begin
						if (k == 0) begin
							word_s[k] <= word0_in;
						end else begin
							word_s[k] <= word_s[(k == 0) ? 0 : k-1];
						end
					end
				end
			end
		end
	endgenerate

	assign out_valid = valid_s[Last];
	assign state_a   = state_s[Last].a;
	assign state_b   = state_s[Last].b;
	assign state_c   = state_s[Last].c;
	assign state_d   = state_s[Last].d;

`ifndef SYNTHESIS
	// a stall freezes every stage
	assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(valid_s))
		else $error("stage valid bits moved during stall");

	// an advance shifts the valid bits by one stage
	assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> valid_s[Last:1] == $past(valid_s[Last-1:0]))
		else $error("stage valid bits did not shift on advance");

	// a request taken at the input enters the first stage
	assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> valid_s[0] == $past(in_valid))
		else $error("first stage valid does not follow accepted request");

	// a stalled middle stage keeps its state
	assert property (@(posedge clk) disable iff (!arst_n)
		(!adv && valid_s[Last/2]) |=> $stable(state_s[Last/2]))
		else $error("middle stage state changed during stall");
`endif

endmodule

@@ sim/md5_single_block_candidate_hash_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// md5_single_block_candidate_hash_tb
// Drives candidate prefix words into the md5 pipeline under several message lengths
// and suffix words, and checks every returned state against the stored want of a
// typed row or an in-bench md5 step model. A short table of hand-picked requests
// comes first, then random traffic with sender and receiver stalls in three mixes.
// ----------------------------------------------------------------------------
module md5_single_block_candidate_hash_tb;

	typedef struct {
		logic [3:0]           len;
		md5c_pkg::word_t      w1;
		md5c_pkg::word_t      w2;
		md5c_pkg::word_t      w3;
		md5c_pkg::word_t      cand;
		bit                   typed;
		md5c_pkg::md5_state_t want;
	} stim_row_t;

	localparam md5c_pkg::word_t SineConst [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	localparam int ShiftAmt [4][4] = '{
		'{7, 12, 17, 22}, '{5, 9, 14, 20}, '{4, 11, 16, 23}, '{6, 10, 15, 21}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_write_en = 1'b0;
	logic [1:0]  cfg_index = md5c_pkg::RegLength;
	logic [31:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [31:0] first_word = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] state_a;
	logic [31:0] state_b;
	logic [31:0] state_c;
	logic [31:0] state_d;

	// bench copy of the configuration registers
	logic [3:0]      cfg_len = '0;
	md5c_pkg::word_t cfg_suffix [1:3] = '{default: '0};

	md5c_pkg::md5_state_t pending_states [$];
	stim_row_t            stim_table [$];
	md5c_pkg::md5_state_t got_state;
	md5c_pkg::md5_state_t want_state;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int error_count = 0;
	int words_sent = 0;
	int states_checked = 0;
	int config_loads = 0;

	md5_single_block_candidate_hash dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.first_word   (first_word),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.state_a      (state_a),
		.state_b      (state_b),
		.state_c      (state_c),
		.state_d      (state_d)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#2_400_000;
		$display("md5_single_block_candidate_hash_tb failed");
		$finish;
	end

	// raw md5 state after 64 steps for one candidate under the current registers
	function automatic md5c_pkg::md5_state_t hash_candidate(input md5c_pkg::word_t cand);
		md5c_pkg::word_t      m [16];
		md5c_pkg::word_t      a, b, c, d, f, t;
		int                   i, grp, g;
		md5c_pkg::md5_state_t res;
		for (i = 0; i < 16; i++) m[i] = '0;
		m[0] = cand;
		m[1] = cfg_suffix[1];
		m[2] = cfg_suffix[2];
		m[3] = cfg_suffix[3];
		m[cfg_len[3:2]] = m[cfg_len[3:2]] | (32'h80 << (8 * cfg_len[1:0]));
		m[14] = {25'd0, cfg_len, 3'd0};
		a = 32'h67452301;
		b = 32'hefcdab89;
		c = 32'h98badcfe;
		d = 32'h10325476;
		for (i = 0; i < 64; i++) begin
			grp = i / 16;
			case (grp)
				0: begin
					f = d ^ (b & (c ^ d));
					g = i;
				end
				1: begin
					f = c ^ (d & (b ^ c));
					g = (5 * i + 1) % 16;
				end
				2: begin
					f = b ^ c ^ d;
					g = (3 * i + 5) % 16;
				end
				default: begin
					f = c ^ (b | ~d);
					g = (7 * i) % 16;
				end
			endcase
			t = a + f + SineConst[i] + m[g];
			a = d;
			d = c;
			c = b;
			b = b + ((t << ShiftAmt[grp][i % 4]) | (t >> (32 - ShiftAmt[grp][i % 4])));
		end
		res.a = a;
		res.b = b;
		res.c = c;
		res.d = d;
		return res;
	endfunction

	// ones over the message bytes of word k that lie below the length
	function automatic md5c_pkg::word_t byte_mask(input logic [3:0] len, input int k);
		int nbytes;
		nbytes = int'(len) - 4 * k;
		if (nbytes <= 0) begin
			return '0;
		end
		if (nbytes >= 4) begin
			return '1;
		end
		return (32'h1 << (8 * nbytes)) - 32'h1;
	endfunction

	task automatic report_error(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		error_count++;
	endtask

	task automatic add_row(input logic [3:0] len, input md5c_pkg::word_t w1,
			input md5c_pkg::word_t w2, input md5c_pkg::word_t w3,
			input md5c_pkg::word_t cand, input bit typed,
			input md5c_pkg::md5_state_t want);
		stim_row_t r;
		r.len = len;
		r.w1 = w1;
		r.w2 = w2;
		r.w3 = w3;
		r.cand = cand;
		r.typed = typed;
		r.want = want;
		stim_table.push_back(r);
	endtask

	task automatic push_word(input md5c_pkg::word_t cand, input bit typed,
			input md5c_pkg::md5_state_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		first_word <= cand;
		do @(posedge clk); while (!in_ready);
		pending_states.push_back(typed ? want : hash_candidate(cand));
		words_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_states.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input md5c_pkg::word_t data);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	task automatic load_config(input logic [3:0] len, input md5c_pkg::word_t w1,
			input md5c_pkg::word_t w2, input md5c_pkg::word_t w3);
		wait_drained();
		// junk above the 4-bit length field must be dropped
		write_reg(md5c_pkg::RegLength, ($urandom & 32'hffff_fff0) | {28'd0, len});
		write_reg(md5c_pkg::RegSuffixW1, w1);
		write_reg(md5c_pkg::RegSuffixW2, w2);
		write_reg(md5c_pkg::RegSuffixW3, w3);
		cfg_write_en <= 1'b0;
		cfg_len = len;
		cfg_suffix[1] = w1;
		cfg_suffix[2] = w2;
		cfg_suffix[3] = w3;
		config_loads++;
	endtask

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			got_state.a = state_a;
			got_state.b = state_b;
			got_state.c = state_c;
			got_state.d = state_d;
			if (pending_states.size() == 0) begin
				report_error($sformatf("unexpected state %h", got_state));
			end else begin
				want_state = pending_states.pop_front();
				if (got_state.a !== want_state.a)
					report_error($sformatf("state_a got %h want %h", got_state.a, want_state.a));
				if (got_state.b !== want_state.b)
					report_error($sformatf("state_b got %h want %h", got_state.b, want_state.b));
				if (got_state.c !== want_state.c)
					report_error($sformatf("state_c got %h want %h", got_state.c, want_state.c));
				if (got_state.d !== want_state.d)
					report_error($sformatf("state_d got %h want %h", got_state.d, want_state.d));
				states_checked++;
			end
		end
	end

	initial begin
		md5c_pkg::md5_state_t none;
		md5c_pkg::md5_state_t empty_msg;
		md5c_pkg::md5_state_t abc_msg;
		stim_row_t            r;
		int                   seg, n;
		logic [3:0]           len;
		md5c_pkg::word_t      w1, w2, w3, cand;
		bit                   noisy;

		none = '0;
		empty_msg = {32'h7246fad3, 32'h14e45506, 32'hff4ea3eb, 32'h6e10a476};
		abc_msg = {32'h310ade8f, 32'hc08226b3, 32'he484b9d8, 32'h624d8cb2};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first row runs on the reset register values: the empty message
		add_row(4'd0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, empty_msg);
		// tail bytes not cleared, pad ored over them
		add_row(4'd0, 32'h0, 32'h0, 32'h0, 32'hffff_ffff, 1'b0, none);
		add_row(4'd3, 32'h0, 32'h0, 32'h0, 32'h0063_6261, 1'b1, abc_msg);
		add_row(4'd3, 32'h0, 32'h0, 32'h0, 32'hff63_6261, 1'b0, none);
		add_row(4'd1, 32'h0, 32'h0, 32'h0, 32'h0000_0061, 1'b0, none);
		add_row(4'd2, 32'h0, 32'h0, 32'h0, 32'h0000_ffff, 1'b0, none);
		add_row(4'd4, 32'h0, 32'h0, 32'h0, 32'hffff_ffff, 1'b0, none);
		add_row(4'd4, 32'hffff_ffff, 32'h0, 32'h0, 32'h8000_0000, 1'b0, none);
		add_row(4'd5, 32'h0000_00ff, 32'h0, 32'h0, 32'h0000_0001, 1'b0, none);
		add_row(4'd7, 32'h00ff_ffff, 32'h0, 32'h0, 32'hdead_beef, 1'b0, none);
		add_row(4'd8, 32'h1234_5678, 32'h0, 32'h0, 32'h0, 1'b0, none);
		add_row(4'd11, 32'hcafe_f00d, 32'h00a5_5a5a, 32'h0, 32'h7fff_ffff, 1'b0, none);
		add_row(4'd12, 32'h0bad_c0de, 32'h8badf00d, 32'hffff_ffff, 32'h5555_aaaa, 1'b0, none);
		add_row(4'd15, 32'haaaa_aaaa, 32'h5555_5555, 32'h00ff_ffff, 32'h0f0f_0f0f, 1'b0, none);
		add_row(4'd15, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, none);
		add_row(4'd15, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b0, none);
		add_row(4'd15, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'h0, 1'b0, none);

		send_idle_pct = 20;
		recv_idle_pct = 30;
		foreach (stim_table[i]) begin
			r = stim_table[i];
			if (r.len != cfg_len || r.w1 != cfg_suffix[1] || r.w2 != cfg_suffix[2] ||
					r.w3 != cfg_suffix[3]) begin
				load_config(r.len, r.w1, r.w2, r.w3);
			end
			push_word(r.cand, r.typed, r.want);
		end

		for (seg = 0; seg < 9; seg++) begin
			// stall mix: slow receiver, then slow sender, then full rate
			if (seg < 3) begin
				send_idle_pct = 7;
				recv_idle_pct = 78;
			end else if (seg < 6) begin
				send_idle_pct = 78;
				recv_idle_pct = 7;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			case (seg)
				1: len = 4'd0;
				4: len = 4'd15;
				7: len = 4'd4;
				default: len = 4'($urandom_range(15));
			endcase
			noisy = (seg == 2 || seg == 5);
			w1 = $urandom & (noisy ? 32'hffff_ffff : byte_mask(len, 1));
			w2 = $urandom & (noisy ? 32'hffff_ffff : byte_mask(len, 2));
			w3 = $urandom & (noisy ? 32'hffff_ffff : byte_mask(len, 3));
			load_config(len, w1, w2, w3);
			for (n = 0; n < 95; n++) begin
				if (seg == 6 && n == 47) begin
					wait_drained();
				end
				cand = $urandom;
				if ($urandom_range(99) < 85) begin
					cand = cand & byte_mask(len, 0);
				end
				push_word(cand, 1'b0, none);
			end
		end

		recv_idle_pct = 0;
		wait_drained();
		repeat (80) @(posedge clk);

		$display("sent %0d candidate words under %0d register loads, checked %0d states",
			words_sent, config_loads, states_checked);
		$display("lengths from 0 to 15, clean and dirty tail bytes, stalls on both sides");
		if (error_count == 0) begin
			$display("md5_single_block_candidate_hash_tb passed");
		end else begin
			$display("md5_single_block_candidate_hash_tb failed");
		end
		$finish;
	end

endmodule
